[rtl/core/kred_pkg.sv]
package kred_pkg;

  localparam int WORD_W   = 32;
  localparam int PROD_W   = 64;
  localparam int LOW_W    = 12;          // one K-RED digit, q = 3*2^12 + 1
  localparam int TOP_SHIFT = 2 * LOW_W;  // second digit boundary for double reduction

  typedef enum logic [2:0] {
    OP_RED      = 3'd0,
    OP_MUL_RED  = 3'd1,
    OP_DRED     = 3'd2,
    OP_MUL_DRED = 3'd3,
    OP_MAC_RED  = 3'd4
  } opcode_t;

  // Word handed from the multiply stage to the reduce stage.
  typedef struct packed {
    opcode_t                     op;
    logic signed [PROD_W-1:0]    x;       // product, or sign-extended operand_a
    logic signed [WORD_W-1:0]    addend;
  } prd_t;

endpackage

[rtl/core/kred_mul_stage.sv]
module kred_mul_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         opcode,
  input  logic signed [kred_pkg::WORD_W-1:0] operand_a,
  input  logic signed [kred_pkg::WORD_W-1:0] operand_b,
  input  logic signed [kred_pkg::WORD_W-1:0] addend,
  output logic                               prd_valid,
  input  logic                               prd_ready,
  output kred_pkg::prd_t                     prd
);

  logic                               in_reg_valid;
  kred_pkg::opcode_t                  op_reg;
  logic signed [kred_pkg::WORD_W-1:0] a_reg;
  logic signed [kred_pkg::WORD_W-1:0] b_reg;
  logic signed [kred_pkg::WORD_W-1:0] c_reg;
  logic signed [kred_pkg::PROD_W-1:0] product;
  kred_pkg::prd_t                     prd_next;
  logic                               load_in;
  logic                               load_prd;

  assign load_prd = in_reg_valid && (!prd_valid || prd_ready);
  assign in_ready = !in_reg_valid || load_prd;
  assign load_in  = in_valid && in_ready;

  assign product = a_reg * b_reg;

  always_comb begin
    prd_next.op     = op_reg;
    prd_next.addend = c_reg;
    case (op_reg)
      kred_pkg::OP_RED, kred_pkg::OP_DRED: begin
        prd_next.x = kred_pkg::PROD_W'(a_reg);
      end
      default: begin
        prd_next.x = product;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      prd_valid    <= 1'b0;
    end else begin
      if (in_ready) begin
        in_reg_valid <= in_valid;
      end
      if (!prd_valid || prd_ready) begin
        prd_valid <= in_reg_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      op_reg <= kred_pkg::opcode_t'(opcode);
      a_reg  <= operand_a;
      b_reg  <= operand_b;
      c_reg  <= addend;
    end
    if (load_prd) begin
      prd <= prd_next;
    end
  end

endmodule

[rtl/core/kred_red_stage.sv]
module kred_red_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               prd_valid,
  output logic                               prd_ready,
  input  kred_pkg::prd_t                     prd,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [kred_pkg::WORD_W-1:0] reduced
);

  logic signed [kred_pkg::PROD_W-1:0] x_sum;
  logic [kred_pkg::WORD_W-1:0]        lo;
  logic [kred_pkg::WORD_W-1:0]        mid;
  logic [kred_pkg::WORD_W-1:0]        hi;
  logic [kred_pkg::WORD_W-1:0]        top;
  logic [kred_pkg::WORD_W-1:0]        single_r;
  logic [kred_pkg::WORD_W-1:0]        double_r;
  logic [kred_pkg::WORD_W-1:0]        reduced_next;
  logic                               load_out;

  assign prd_ready = !out_valid || out_ready;
  assign load_out  = prd_valid && prd_ready;

  // Only the multiply-add opcode folds in the addend.
  assign x_sum = (prd.op == kred_pkg::OP_MAC_RED) ?
                 prd.x + kred_pkg::PROD_W'(prd.addend) : prd.x;

  assign lo  = kred_pkg::WORD_W'(x_sum[kred_pkg::LOW_W-1:0]);
  assign mid = kred_pkg::WORD_W'(x_sum[kred_pkg::TOP_SHIFT-1:kred_pkg::LOW_W]);
  assign hi  = x_sum[kred_pkg::LOW_W+kred_pkg::WORD_W-1:kred_pkg::LOW_W];
  assign top = x_sum[kred_pkg::TOP_SHIFT+kred_pkg::WORD_W-1:kred_pkg::TOP_SHIFT];

  assign single_r = (lo << 1) + lo - hi;
  assign double_r = (lo << 3) + lo - ((mid << 1) + mid) + top;

  always_comb begin
    case (prd.op)
      kred_pkg::OP_RED, kred_pkg::OP_MUL_RED, kred_pkg::OP_MAC_RED: begin
        reduced_next = single_r;
      end
      kred_pkg::OP_DRED, kred_pkg::OP_MUL_DRED: begin
        reduced_next = double_r;
      end
      default: begin
        reduced_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prd_ready) begin
      out_valid <= prd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      reduced <= $signed(reduced_next);
    end
  end

endmodule

[rtl/core/kred_multiply_reduce_unit.sv]
// Channel   Dir  Signals                  Contents
// s_*       in   tvalid tready tdata tuser  tuser: opcode; tdata: operand_a, operand_b, addend
// m_*       out  tvalid tready tdata        tdata: reduced
//
// Three register stages: input word, 64-bit product, reduced result.
// One word per cycle unless m_tready stalls; m_tvalid follows via the product and result registers.
// The 32x32 signed multiplier sets the first stage, the 64-bit add and
// K-RED shift/add network set the second.
// Each stage advances on its own, so bubbles collapse and s_tready stays high
// while the output register is empty. rst clears only the valid flags.
module kred_multiply_reduce_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // [31:0] operand_a, [63:32] operand_b, [95:64] addend
  input  logic [2:0]   s_tuser,   // [2:0] opcode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata    // [31:0] reduced
);

  logic                               prd_valid;
  logic                               prd_ready;
  kred_pkg::prd_t                     prd;
  logic signed [kred_pkg::WORD_W-1:0] reduced;

  // Multiply stage: hold the input word, form the product or pass operand_a.
  kred_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .opcode    (s_tuser),
    .operand_a ($signed(s_tdata[31:0])),
    .operand_b ($signed(s_tdata[63:32])),
    .addend    ($signed(s_tdata[95:64])),
    .prd_valid (prd_valid),
    .prd_ready (prd_ready),
    .prd       (prd)
  );

  // Reduce stage: add the addend (multiply-add only), apply single or double K-RED, register result.
  kred_red_stage u_red (
    .clk       (clk),
    .rst       (rst),
    .prd_valid (prd_valid),
    .prd_ready (prd_ready),
    .prd       (prd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .reduced   (reduced)
  );

  assign m_tdata = reduced;

  // An empty output register must never back-pressure the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("s_tready low with empty output register");

  // A new result only appears from a word held in the product stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(prd_valid))
    else $error("result appeared without a product word");

  // Reset empties the pipeline.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid && !prd_valid)
    else $error("pipeline not empty after reset");

endmodule

[bench/kred_checker.sv]
// Scoreboard for the K-RED unit: predicts each reduced word from the accepted
// input word and compares it against the output stream in order.
module kred_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        check_end,
  output int          mismatches,
  output int          in_flight
);

  typedef struct {
    logic [2:0]                  op;
    logic [kred_pkg::WORD_W-1:0] a;
    logic [kred_pkg::WORD_W-1:0] b;
    logic [kred_pkg::WORD_W-1:0] c;
    logic [kred_pkg::WORD_W-1:0] reduced;
  } kred_job_t;

  kred_job_t pending_q[$];

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  // Single reduction: 3*lo - (x >>> 12); double: 9*lo - 3*mid + (x >>> 24).
  // Shifted terms keep 32 bits of the 64-bit value, sums wrap at 32 bits.
  function automatic logic [kred_pkg::WORD_W-1:0] kred_value(
    input logic [2:0]                         op,
    input logic signed [kred_pkg::WORD_W-1:0] a,
    input logic signed [kred_pkg::WORD_W-1:0] b,
    input logic signed [kred_pkg::WORD_W-1:0] c);
    logic signed [kred_pkg::PROD_W-1:0] x;
    logic [kred_pkg::WORD_W-1:0]        r;
    x = a;
    case (op)
      kred_pkg::OP_MUL_RED, kred_pkg::OP_MUL_DRED: x = a * b;
      kred_pkg::OP_MAC_RED:                        x = a * b + c;
      default: ;
    endcase
    case (op)
      kred_pkg::OP_RED, kred_pkg::OP_MUL_RED, kred_pkg::OP_MAC_RED:
        r = 32'd3 * x[kred_pkg::LOW_W-1:0] - x[kred_pkg::LOW_W +: kred_pkg::WORD_W];
      kred_pkg::OP_DRED, kred_pkg::OP_MUL_DRED:
        r = 32'd9 * x[kred_pkg::LOW_W-1:0]
            - 32'd3 * x[kred_pkg::LOW_W +: kred_pkg::LOW_W]
            + x[kred_pkg::TOP_SHIFT +: kred_pkg::WORD_W];
      default:
        r = '0;
    endcase
    return r;
  endfunction

  task automatic report(input string what);
    $display("%0t kred check: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    kred_job_t job;
    if (!rst) begin
      // Drain first: a registered output never answers the word accepted this edge.
      if (m_tvalid && m_tready) begin
        if (pending_q.size() == 0) begin
          report($sformatf("unexpected word %h", m_tdata));
        end else begin
          job = pending_q.pop_front();
          if (m_tdata !== job.reduced)
            report($sformatf("op %0d a %h b %h c %h: got %h, want %h",
                             job.op, job.a, job.b, job.c, m_tdata, job.reduced));
        end
      end
      if (s_tvalid && s_tready) begin
        job.op      = s_tuser;
        job.a       = s_tdata[31:0];
        job.b       = s_tdata[63:32];
        job.c       = s_tdata[95:64];
        job.reduced = kred_value(job.op, job.a, job.b, job.c);
        pending_q.push_back(job);
      end
      if (check_end && pending_q.size() != 0)
        report($sformatf("%0d words never arrived", pending_q.size()));
      in_flight <= pending_q.size();
    end
  end

endmodule

[bench/tb_top.sv]
module tb_top;

  localparam int          IDLE_PCT     = 31;
  localparam int          QUIET_LIMIT  = 1000;
  localparam int          HOLD_CYCLES  = 48;
  localparam int          HOLD_AT_WORD = 150;
  localparam int          RANDOM_WORDS = 830;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [2:0]  OP_UNUSED_LO = 3'd5;
  localparam logic [2:0]  OP_UNUSED_HI = 3'd7;
  localparam logic [31:0] W_MIN        = 32'h8000_0000;
  localparam logic [31:0] W_MAX        = 32'h7FFF_FFFF;
  localparam logic [31:0] W_ONES       = 32'hFFFF_FFFF;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = kred_pkg::OP_RED;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        calm      = 1'b0;
  logic        check_end = 1'b0;
  int          mismatches;
  int          in_flight;
  int          quiet_cycles = 0;

  always #4 clk = ~clk;

  kred_multiply_reduce_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  kred_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .check_end  (check_end),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // Offer one word, idling at random first; valid stays up after the handshake
  // so back-to-back words need no extra assignment.
  task automatic send_word(input logic [2:0] op, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] c);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {c, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mix of full-range, NTT-sized, extreme and power-of-two operands.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(5))
      0, 1, 2: v = $urandom;
      3:       v = $urandom_range(32767) - 16384;
      4: begin
        case ($urandom_range(4))
          0:       v = W_MIN;
          1:       v = W_MAX;
          2:       v = W_ONES;
          3:       v = 32'd1;
          default: v = '0;
        endcase
      end
      default: begin
        v = 32'd1 << $urandom_range(31);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pick_opcode();
    if ($urandom_range(19) == 0) return 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    return 3'($urandom_range(kred_pkg::OP_MAC_RED, kred_pkg::OP_RED));
  endfunction

  // Receiver: random stalls, one long hold-off once enough words came back.
  initial begin
    int got;
    got = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (got == HOLD_AT_WORD) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        got++;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        @(posedge clk);
        if (m_tvalid && m_tready) got++;
      end
    end
  end

  // Stall watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("kred_multiply_reduce_unit: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: operand extremes, wide products, every opcode, unused opcodes.
    send_word(kred_pkg::OP_RED,      '0,     W_ONES, W_ONES);
    send_word(kred_pkg::OP_RED,      W_MAX,  W_MIN,  W_MAX);
    send_word(kred_pkg::OP_RED,      W_MIN,  W_MAX,  W_MIN);
    send_word(kred_pkg::OP_RED,      W_ONES, '0,     '0);
    send_word(kred_pkg::OP_MUL_RED,  W_MIN,  W_MIN,  W_ONES);
    send_word(kred_pkg::OP_MUL_RED,  W_MAX,  W_MAX,  W_MIN);
    send_word(kred_pkg::OP_MUL_RED,  W_MIN,  W_MAX,  W_MAX);
    send_word(kred_pkg::OP_MUL_RED,  W_ONES, W_ONES, '0);
    send_word(kred_pkg::OP_MUL_RED,  32'd12289, 32'd12289, '0);
    send_word(kred_pkg::OP_DRED,     W_MIN,  W_ONES, W_ONES);
    send_word(kred_pkg::OP_DRED,     W_MAX,  '0,     W_MAX);
    send_word(kred_pkg::OP_DRED,     32'h00FF_FFFF, W_MIN, W_MIN);
    send_word(kred_pkg::OP_DRED,     W_ONES, W_MAX,  '0);
    send_word(kred_pkg::OP_MUL_DRED, W_MIN,  W_MIN,  W_MAX);
    send_word(kred_pkg::OP_MUL_DRED, W_MAX,  W_MIN,  W_ONES);
    send_word(kred_pkg::OP_MUL_DRED, W_MAX,  W_MAX,  '0);
    send_word(kred_pkg::OP_MAC_RED,  W_MIN,  W_MIN,  W_MAX);
    send_word(kred_pkg::OP_MAC_RED,  W_MAX,  W_MAX,  W_MIN);
    send_word(kred_pkg::OP_MAC_RED,  '0,     W_MAX,  W_MIN);
    send_word(kred_pkg::OP_MAC_RED,  W_ONES, 32'd1,  32'd1);
    for (int u = OP_UNUSED_LO; u <= OP_UNUSED_HI; u++)
      send_word(3'(u), $urandom, $urandom, $urandom);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Full-rate stretch on both sides.
      if (n == 300) calm <= 1'b1;
      if (n == 450) calm <= 1'b0;
      // Let the pipe run dry once before carrying on.
      if (n == 600) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
      end
      send_word(pick_opcode(), pick_operand(), pick_operand(), pick_operand());
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    check_end <= 1'b1;
    @(posedge clk);
    check_end <= 1'b0;
    @(posedge clk);
    if (mismatches == 0) begin
      $display("kred_multiply_reduce_unit: match");
    end else begin
      $display("kred_multiply_reduce_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/kred_pkg.sv
rtl/core/kred_mul_stage.sv
rtl/core/kred_red_stage.sv
rtl/core/kred_multiply_reduce_unit.sv
bench/kred_checker.sv
bench/tb_top.sv
